[design/irq_least_count_steering_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the interrupt least-count steering block
// Shared property wrappers, clocked on aclk; the first two are held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef IRQ_LEAST_COUNT_STEERING_MACROS_SVH
`define IRQ_LEAST_COUNT_STEERING_MACROS_SVH

// Check a consequent in the same cycle as its antecedent, outside reset.
`define IRQ_LCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("irq_lcs assertion failed");

// Check a consequent in the cycle after its antecedent, outside reset.
`define IRQ_LCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("irq_lcs assertion failed");

// Check a consequent in the cycle after its antecedent, reset included.
`define IRQ_LCS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("irq_lcs assertion failed");

`endif

[design/irq_lcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_lcs_pkg
// Shared types and constants of the interrupt least-count steering block.
// ----------------------------------------------------------------------------
package irq_lcs_pkg;

    // Default sizes of the counter table
    localparam int MAX_CORES_DEF  = 16;
    localparam int IRQ_LINES_DEF  = 16;
    localparam int COUNT_BITS_DEF = 64;

    // Configuration port widths and register indexes
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC_IO_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCING_ENABLE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_INTERVAL  = 8'd3;

    // Remainder unit: bits retired per cycle and remainder width
    localparam int MOD_RADIX = 4;
    localparam int REM_W     = 17;

    typedef struct packed {
        logic [3:0] core_id;
        logic [3:0] irq_line;
        logic       mode;
    } in_item_t;

    typedef struct packed {
        logic       eoi_to_local_apic;
        logic       route_valid;
        logic [3:0] route_core;
        logic       counts_cleared;
    } out_item_t;

    typedef struct packed {
        logic        symmetric_io_mode;
        logic        balancing_enable;
        logic [4:0]  core_count;
        logic [15:0] balance_interval;
    } cfg_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic       in_range;
        logic       mode;
        logic [3:0] core_id;
        logic [3:0] irq_line;
    } cmd_t;

    typedef struct packed {
        logic init_done;
    } back_status_t;

endpackage

[design/irq_least_count_steering.sv]
`timescale 1ns / 1ps
// Requests are queued and handled by the back one at a time: read, count, an optional
// rebalance remainder, a core scan and a line clear, then the result is registered.
// The back takes a new request from the queue only once the previous result is loaded
// into the output register; the count update, core scan and line clear share one table.
// Reset: synchronous, active low; after reset the table is cleared one entry a cycle,
// all 2**ADDR_W entries of the back (256 at defaults), with s_ready low.
// ----------------------------------------------------------------------------
// irq_least_count_steering
// Per-core, per-IRQ event counters with least-count interrupt steering.
// ----------------------------------------------------------------------------
module irq_least_count_steering
    import irq_lcs_pkg::*;
#(
    parameter int MAX_CORES  = MAX_CORES_DEF,
    parameter int IRQ_LINES  = IRQ_LINES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cfg_t         cfg_reg, cfg_next;
    back_status_t status;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_not_empty;
    cmd_t         q_in;
    cmd_t         q_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SYMMETRIC_IO_MODE: cfg_next.symmetric_io_mode = cfg_wdata[0];
                CFG_BALANCING_ENABLE:  cfg_next.balancing_enable  = cfg_wdata[0];
                CFG_CORE_COUNT:        cfg_next.core_count        = cfg_wdata[4:0];
                CFG_BALANCE_INTERVAL:  cfg_next.balance_interval  = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.symmetric_io_mode <= 1'b0;
            cfg_reg.balancing_enable  <= 1'b0;
            cfg_reg.core_count        <= 5'd1;
            cfg_reg.balance_interval  <= 16'd10;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    irq_lcs_front #(
        .MAX_CORES (MAX_CORES),
        .IRQ_LINES (IRQ_LINES)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .status  (status),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    irq_lcs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    irq_lcs_back #(
        .MAX_CORES  (MAX_CORES),
        .IRQ_LINES  (IRQ_LINES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[design/irq_lcs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_lcs_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module irq_lcs_fifo
    import irq_lcs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic not_empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/irq_lcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_lcs_front
// Accepts interrupt events, checks core and line range, queues the request.
// ----------------------------------------------------------------------------
module irq_lcs_front
    import irq_lcs_pkg::*;
#(
    parameter int MAX_CORES = MAX_CORES_DEF,
    parameter int IRQ_LINES = IRQ_LINES_DEF
) (
    input  logic         s_valid,
    output logic         s_ready,
    input  in_item_t     s_data,
    input  back_status_t status,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_data
);

    logic core_ok;
    logic line_ok;

    // Hold off requests while the table is being cleared or the queue is full
    assign s_ready = status.init_done && !q_full;
    assign q_push  = s_valid && s_ready;

    // Classify the request
    assign core_ok = (32'(s_data.core_id) < 32'(MAX_CORES));
    assign line_ok = (32'(s_data.irq_line) < 32'(IRQ_LINES));

    always_comb begin
        q_data.in_range = core_ok && line_ok;
        q_data.mode     = s_data.mode;
        q_data.core_id  = s_data.core_id;
        q_data.irq_line = s_data.irq_line;
    end

endmodule

[design/irq_lcs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_lcs_back
// Counter table, interval remainder unit, least-count scan and line clearing.
// ----------------------------------------------------------------------------
module irq_lcs_back
    import irq_lcs_pkg::*;
#(
    parameter int MAX_CORES  = MAX_CORES_DEF,
    parameter int IRQ_LINES  = IRQ_LINES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  cmd_t         q_data,
    output logic         q_pop,
    output back_status_t status,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_data
);

    localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int LINE_W = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int ADDR_W = CORE_W + LINE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int IDX_W  = $clog2(MAX_CORES + 1);
    localparam int STEPS  = (COUNT_BITS + MOD_RADIX - 1) / MOD_RADIX;
    localparam int PAD_W  = STEPS * MOD_RADIX;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [COUNT_BITS-1:0] CNT_NEAR_FULL = {{(COUNT_BITS-1){1'b1}}, 1'b0};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Counter table
    logic [COUNT_BITS-1:0] mem_array [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     init_addr_reg, init_addr_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PAD_W-1:0]      div_reg, div_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [IDX_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      issue_reg, issue_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  pend_reg, pend_next;
    logic [COUNT_BITS-1:0] min_cnt_reg, min_cnt_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic                  clear_reg, clear_next;
    out_item_t             res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    logic [COUNT_BITS-1:0] cnt_inc;
    logic [REM_W-1:0]      rem_w;
    logic [REM_W-1:0]      divisor;
    logic [PAD_W-1:0]      div_w;
    logic [IDX_W-1:0]      n_cap;
    logic [ADDR_W-1:0]     cmd_addr;
    logic [ADDR_W-1:0]     scan_addr;

    assign m_valid          = m_valid_reg;
    assign m_data           = m_item_reg;
    assign status.init_done = (state_reg != ST_INIT);

    assign cnt_inc   = rdata_reg + 1'b1;
    assign divisor   = {1'b0, cfg.balance_interval};
    assign n_cap     = (32'(cfg.core_count) > 32'(MAX_CORES)) ? IDX_W'(MAX_CORES)
                                                               : IDX_W'(cfg.core_count);
    assign cmd_addr  = {CORE_W'(cmd_reg.core_id), LINE_W'(cmd_reg.irq_line)};
    assign scan_addr = {issue_reg[CORE_W-1:0], LINE_W'(cmd_reg.irq_line)};

    // Clear the table after reset, then sequence one request: read, count, remainder, scan, clear, report
    always_comb begin
        state_next     = state_reg;
        init_addr_next = init_addr_reg;
        cmd_next       = cmd_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_next      = pend_reg;
        min_cnt_next   = min_cnt_reg;
        min_idx_next   = min_idx_reg;
        clear_next     = clear_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = cmd_addr;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cmd_addr;
        q_pop          = 1'b0;
        rem_w          = rem_reg;
        div_w          = div_reg;

        // Drop the output once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                // Zero one table entry per cycle after reset
                mem_we         = 1'b1;
                mem_waddr      = init_addr_reg;
                init_addr_next = init_addr_reg + 1'b1;
                if (init_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    res_next = '0;
                    if (q_data.in_range) begin
                        mem_re     = 1'b1;
                        mem_raddr  = {CORE_W'(q_data.core_id), LINE_W'(q_data.irq_line)};
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                // Count the event and decide on a rebalance check
                mem_we    = 1'b1;
                mem_wdata = cnt_inc;
                if (cmd_reg.mode && cfg.balancing_enable && (cnt_inc != '0)
                    && (cfg.balance_interval != '0)) begin
                    div_next   = PAD_W'(cnt_inc);
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MOD: begin
                // Retire MOD_RADIX dividend bits per cycle into the remainder
                for (int j = 0; j < MOD_RADIX; j++) begin
                    rem_w = {rem_w[REM_W-2:0], div_w[PAD_W-1]};
                    div_w = {div_w[PAD_W-2:0], 1'b0};
                    if (rem_w >= divisor) begin
                        rem_w = rem_w - divisor;
                    end
                end
                rem_next  = rem_w;
                div_next  = div_w;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    if (rem_w == '0) begin
                        n_next       = n_cap;
                        issue_next   = '0;
                        pend_next    = 1'b0;
                        min_cnt_next = '1;
                        min_idx_next = '0;
                        clear_next   = 1'b0;
                        state_next   = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // Compare the counter read in the previous cycle
                if (pend_reg) begin
                    if (rdata_reg < min_cnt_reg) begin
                        min_cnt_next = rdata_reg;
                        min_idx_next = cmp_idx_reg;
                    end else if (rdata_reg >= CNT_NEAR_FULL) begin
                        clear_next = 1'b1;
                    end
                end
                // Issue the next core's read
                if (issue_reg != n_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = scan_addr;
                    issue_next   = issue_reg + 1'b1;
                    cmp_idx_next = issue_reg;
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_next.route_valid = 1'b1;
                        res_next.route_core  = 4'(min_idx_reg);
                        if (clear_reg) begin
                            issue_next = '0;
                            state_next = ST_CLEAR;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                // Zero this line's counters on every scanned core
                mem_we     = 1'b1;
                mem_waddr  = scan_addr;
                issue_next = issue_reg + 1'b1;
                if (issue_next == n_reg) begin
                    res_next.counts_cleared = 1'b1;
                    state_next              = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_item_next                   = res_reg;
                    m_item_next.eoi_to_local_apic = cfg.symmetric_io_mode;
                    state_next                    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            m_valid_reg   <= m_valid_next;
            pend_reg      <= pend_next;
        end
        cmd_reg     <= cmd_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        n_reg       <= n_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        min_cnt_reg <= min_cnt_next;
        min_idx_reg <= min_idx_next;
        clear_reg   <= clear_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    // Table write port and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem_array[mem_raddr];
        end
    end

endmodule

[design/irq_lcs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_lcs_checker
// Port-level checks of the steering block, bound to its top level.
// ----------------------------------------------------------------------------
`include "irq_least_count_steering_macros.svh"

module irq_lcs_checker
    import irq_lcs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result
    `IRQ_LCS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data))

    // Keep route fields clear when no reroute is reported
    `IRQ_LCS_ASSERT_NOW(a_no_route_fields, m_valid && !m_data.route_valid, (m_data.route_core == 4'd0) && !m_data.counts_cleared)

    // Report a clear only with a reroute
    `IRQ_LCS_ASSERT_NOW(a_clear_needs_route, m_valid && m_data.counts_cleared, m_data.route_valid)

    // Refuse requests right after reset while the table is swept
    `IRQ_LCS_ASSERT_NEXT_ALWAYS(a_no_accept_after_reset, !aresetn, !s_ready && !m_valid)

endmodule

bind irq_least_count_steering irq_lcs_checker u_irq_lcs_checker (.*);
